// ===== rtl/core/lrul_pkg.sv =====
// ----------------------------------------------------------------------------
// lrul_pkg
// Shared types and codes for the LRU replacement list: the input and result
// items, command and status codes, and the control bundle sent to each cell.
// ----------------------------------------------------------------------------
package lrul_pkg;

  localparam int KEY_W = 16;
  localparam int CNT_W = 5;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_VICTIM = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] victim_key;
    logic [CNT_W-1:0] entry_count;
  } out_item_t;

  // Control bundle that the controller broadcasts to every cell.
  typedef struct packed {
    logic match;       // capture the key compare into the hit flag
    logic remove_hit;  // close the gap at the hit position
    logic remove_all;  // close the gap at the head (victim)
    logic touch;       // the top valid cell of the chain takes the new key
    logic append;      // the first free cell takes the new key
  } cell_ctl_t;

endpackage

// ===== rtl/core/lrul_cell.sv =====
// ----------------------------------------------------------------------------
// lrul_cell
// One position of the ordered key chain. Holds a key and a valid bit,
// compares against the command key, and takes its upper neighbor's entry
// when a gap at or below it closes, or the command key on append or touch.
// ----------------------------------------------------------------------------
module lrul_cell #(
  parameter int KEY_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lrul_pkg::cell_ctl_t  ctl,
  input  logic [KEY_BITS-1:0]  key_in,
  input  logic [KEY_BITS-1:0]  up_key,
  input  logic                 up_valid,
  input  logic                 down_valid,
  input  logic                 seen_in,
  output logic                 seen_out,
  output logic                 hit,
  output logic [KEY_BITS-1:0]  key,
  output logic                 valid
);
  import lrul_pkg::*;

  logic shift;
  logic is_top;

  // A hit at this position or below leaves a gap that this cell must close.
  assign seen_out = seen_in | hit;
  assign shift    = ctl.remove_all | (ctl.remove_hit & seen_out);
  assign is_top   = valid & ~up_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctl.match) begin
        hit <= valid && (key == key_in);
      end
      if (shift) begin
        if (!(ctl.touch && is_top)) begin
          valid <= up_valid;
        end
      end else if (ctl.append && !valid && down_valid) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      if (ctl.touch && is_top) begin
        key <= key_in;
      end else begin
        key <= up_key;
      end
    end else if (ctl.append && !valid && down_valid) begin
      key <= key_in;
    end
  end

endmodule

// ===== rtl/core/lru_replacement_list_unit.sv =====
// ----------------------------------------------------------------------------
// lru_replacement_list_unit
// LRU ordered key set built as a shifting chain of cells, least recent key
// in cell 0. Handles insert/touch, take victim and erase commands.
// ----------------------------------------------------------------------------
//  Channel   Signals                            Payload
//  input     in_valid, in_stall, in_item        cmd, key
//  output    out_valid, out_stall, out_item     status, victim_key, entry_count
//
//  Each item goes through accept, then per-cell key compare, then chain update.
//  The update waits while the output register holds a result not yet taken.
//  in_stall is high from accept until the update cycle completes.
//  Reset (rst, synchronous) empties the chain; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_replacement_list_unit #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lrul_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lrul_pkg::out_item_t out_item
);
  import lrul_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MATCH = 2'd1;
  localparam logic [1:0] PH_UPD   = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [1:0]          cmd;
  logic [KEY_BITS-1:0] key;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;

  logic [KEY_BITS-1:0] cell_key   [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_hit;
  logic [CAPACITY:0]   seen;

  cell_ctl_t           ctl;
  logic                in_take;
  logic                upd_go;
  logic                any_hit;
  logic                is_full;
  logic                is_empty;
  logic [1:0]          status_next;
  logic [KEY_BITS-1:0] victim_next;

  logic [KEY_W+KEY_BITS-1:0] key_wide;
  logic [KEY_BITS+KEY_W-1:0] victim_wide;
  logic [CW+CNT_W-1:0]       count_wide;

  assign in_stall = (state != PH_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign upd_go   = (state == PH_UPD) && (!out_valid || !out_stall);

  assign key_wide = {{KEY_BITS{1'b0}}, in_item.key};

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd <= in_item.cmd;
      key <= key_wide[KEY_BITS-1:0];
    end
  end

  // The hit chain runs bottom to top; its far end says whether any cell hit.
  assign seen[0]  = 1'b0;
  assign any_hit  = seen[CAPACITY];
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [KEY_BITS-1:0] up_key;
      logic                up_valid;
      logic                down_valid;
      if (gi == CAPACITY - 1) begin : g_last
        assign up_key   = key;
        assign up_valid = 1'b0;
      end else begin : g_mid
        assign up_key   = cell_key[gi+1];
        assign up_valid = cell_valid[gi+1];
      end
      if (gi == 0) begin : g_first
        assign down_valid = 1'b1;
      end else begin : g_rest
        assign down_valid = cell_valid[gi-1];
      end
      lrul_cell #(
        .KEY_BITS(KEY_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .key_in    (key),
        .up_key    (up_key),
        .up_valid  (up_valid),
        .down_valid(down_valid),
        .seen_in   (seen[gi]),
        .seen_out  (seen[gi+1]),
        .hit       (cell_hit[gi]),
        .key       (cell_key[gi]),
        .valid     (cell_valid[gi])
      );
    end
  endgenerate

  always_comb begin
    ctl         = '0;
    ctl.match   = (state == PH_MATCH);
    count_next  = count;
    status_next = ST_OK;
    victim_next = '0;
    state_next  = state;
    case (state)
      PH_IDLE: begin
        if (in_take) begin
          state_next = PH_MATCH;
        end
      end
      PH_MATCH: begin
        state_next = PH_UPD;
      end
      PH_UPD: begin
        case (cmd)
          CMD_INSERT: begin
            if (any_hit) begin
              ctl.remove_hit = upd_go;
              ctl.touch      = upd_go;
            end else if (is_full) begin
              status_next = ST_FULL;
            end else begin
              ctl.append = upd_go;
              count_next = count + 1'b1;
            end
          end
          CMD_VICTIM: begin
            if (is_empty) begin
              status_next = ST_MISS;
            end else begin
              ctl.remove_all = upd_go;
              victim_next    = cell_key[0];
              count_next     = count - 1'b1;
            end
          end
          CMD_ERASE: begin
            if (any_hit) begin
              ctl.remove_hit = upd_go;
              count_next     = count - 1'b1;
            end else begin
              status_next = ST_MISS;
            end
          end
          default: begin
          end
        endcase
        if (upd_go) begin
          state_next = PH_IDLE;
        end
      end
      default: begin
        state_next = PH_IDLE;
      end
    endcase
  end

  assign victim_wide = {{KEY_W{1'b0}}, victim_next};
  assign count_wide  = {{CNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (upd_go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_item.status      <= status_next;
      out_item.victim_key  <= victim_wide[KEY_W-1:0];
      out_item.entry_count <= count_wide[CNT_W-1:0];
    end
  end

  // Valid cells always form a run from cell 0 whose length is the count.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == count)
    else $error("valid cells disagree with count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  // Held keys are distinct, so at most one cell can hit.
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    state == PH_UPD |-> $onehot0(cell_hit))
    else $error("more than one cell hit");

  a_accept_to_match: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == PH_MATCH)
    else $error("accepted item did not enter compare");

endmodule
